[hdl/tdp_pkg.sv]
// shared widths, constants and types of the tone divider select block
package tdp_pkg;

    localparam int unsigned FREQ_W      = 16;
    localparam int unsigned CLK_W       = 27;
    localparam int unsigned CMP_W       = 16;
    localparam int unsigned SEL_W       = 2;
    localparam int unsigned NUM_LANES   = 3;
    // quotient of clock over frequency
    localparam int unsigned QUO_W       = CLK_W;
    // half period count, up to 2^16 for a usable candidate
    localparam int unsigned CNT_W       = CMP_W + 1;
    // clock over twice the prescaler, widest for the divide-by-1 lane
    localparam int unsigned REAL_W      = CLK_W - 1;
    localparam int unsigned S_DATA_W    = 16;
    localparam int unsigned M_DATA_W    = 24;

    localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(16000000);
    localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(65536);

    // prescaler codes
    localparam logic [SEL_W-1:0] SEL_DIV1  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_DIV8  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_DIV64 = 2'd2;

    // log2 of each prescaler
    localparam int unsigned PRESC_SHIFT [NUM_LANES] = '{0, 3, 6};

    // data carried beside each candidate divider
    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic              skip;
        logic [CMP_W-1:0]  cmp;
    } tdp_lane_t;

endpackage

[hdl/tdp_div_pipe.sv]
// pipelined restoring divider, one quotient bit per stage, with sideband data
module tdp_div_pipe
    import tdp_pkg::*;
#(
    parameter int unsigned NUM_W  = 27,
    parameter int unsigned DEN_W  = 16,
    parameter int unsigned SIDE_W = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);

    logic              vld_reg  [NUM_W];
    logic [NUM_W-1:0]  num_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  quo_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic              src_vld;
        logic [NUM_W-1:0]  src_num;
        logic [DEN_W-1:0]  src_den;
        logic [DEN_W-1:0]  src_rem;
        logic [NUM_W-1:0]  src_quo;
        logic [SIDE_W-1:0] src_side;
        logic [DEN_W:0]    shifted;
        logic [DEN_W:0]    diff;

        if (g == 0) begin : g_first
            assign src_vld  = in_valid;
            assign src_num  = in_num;
            assign src_den  = in_den;
            assign src_rem  = '0;
            assign src_quo  = '0;
            assign src_side = in_side;
        end else begin : g_next
            assign src_vld  = vld_reg[g-1];
            assign src_num  = num_reg[g-1];
            assign src_den  = den_reg[g-1];
            assign src_rem  = rem_reg[g-1];
            assign src_quo  = quo_reg[g-1];
            assign src_side = side_reg[g-1];
        end

        // bring down the next dividend bit and trial subtract
        assign shifted = {src_rem, src_num[NUM_W-1-g]};
        assign diff    = shifted - {1'b0, src_den};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (ce) begin
                vld_reg[g] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                num_reg[g]  <= src_num;
                den_reg[g]  <= src_den;
                side_reg[g] <= src_side;
                quo_reg[g]  <= {src_quo[NUM_W-2:0], ~diff[DEN_W]};
                if (!diff[DEN_W]) begin
                    rem_reg[g] <= diff[DEN_W-1:0];
                end else begin
                    rem_reg[g] <= shifted[DEN_W-1:0];
                end
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_quo   = quo_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

[hdl/tdp_pick.sv]
// error of each candidate, choice of the best one and the output register
module tdp_pick
    import tdp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  tdp_lane_t         lane [NUM_LANES],
    input  logic [REAL_W-1:0] real_freq [NUM_LANES],
    output logic              out_valid,
    output logic              tone_on,
    output logic [SEL_W-1:0]  prescale_select,
    output logic [CMP_W-1:0]  compare_value
);

    localparam logic [SEL_W-1:0] SEL_CODE [NUM_LANES] = '{SEL_DIV1, SEL_DIV8, SEL_DIV64};

    logic [REAL_W-1:0] err [NUM_LANES];
    logic              best_ok;
    logic [REAL_W-1:0] min_err;
    logic [SEL_W-1:0]  best_sel;
    logic [CMP_W-1:0]  best_cmp;
    logic              valid_reg;
    logic              tone_on_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [CMP_W-1:0]  cmp_reg;

    // absolute error of the produced frequency
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_err
        logic [REAL_W-1:0] f_ext;
        assign f_ext  = REAL_W'(lane[0].freq);
        assign err[k] = (real_freq[k] > f_ext) ? (real_freq[k] - f_ext)
                                               : (f_ext - real_freq[k]);
    end

    // first candidate with the strictly smallest error
    always_comb begin
        best_ok  = 1'b0;
        min_err  = '0;
        best_sel = SEL_DIV1;
        best_cmp = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            if (!lane[k].skip && (!best_ok || err[k] < min_err)) begin
                best_ok  = 1'b1;
                min_err  = err[k];
                best_sel = SEL_CODE[k];
                best_cmp = lane[k].cmp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    // silence forces everything to zero
    always_ff @(posedge aclk) begin
        if (ce) begin
            if (lane[0].freq == '0) begin
                tone_on_reg <= 1'b0;
                sel_reg     <= SEL_DIV1;
                cmp_reg     <= '0;
            end else begin
                tone_on_reg <= 1'b1;
                sel_reg     <= best_sel;
                cmp_reg     <= best_cmp;
            end
        end
    end

    assign out_valid       = valid_reg;
    assign tone_on         = tone_on_reg;
    assign prescale_select = sel_reg;
    assign compare_value   = cmp_reg;

endmodule

[hdl/tone_divider_select.sv]
// Tone divider select: for each requested tone frequency this block returns the prescaler
// (1, 8 or 64) and the 16-bit compare value of a toggle-on-match timer that come closest
// to it; a frequency of zero returns silence. It is fully pipelined and takes one
// transaction per cycle unless the output stalls. A 27-stage divider for clock over
// frequency feeds a count register, three parallel 26-stage dividers for the produced
// frequencies and the output register. A stalled result output holds the whole pipeline.
// The clock register may be written only while no transaction is in flight.
module tone_divider_select
    import tdp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CLK_W-1:0]    cfg_wr_data,   // clock_hz
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,       // [15:0] tone_freq
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] tone_on, [2:1] prescale_select, [18:3] compare_value, [23:19] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [CLK_W-1:0]  clock_hz_reg;
    logic              ce;
    logic              q_valid;
    logic [QUO_W-1:0]  q_quo;
    logic [FREQ_W-1:0] q_freq;
    logic              prep_valid_reg;
    tdp_lane_t         prep_lane_reg [NUM_LANES];
    logic [CNT_W-1:0]  prep_cnt_reg  [NUM_LANES];
    logic              lane_valid    [NUM_LANES];
    tdp_lane_t         lane_side     [NUM_LANES];
    logic [REAL_W-1:0] lane_real     [NUM_LANES];
    logic              pick_valid;
    logic              tone_on;
    logic [SEL_W-1:0]  prescale_select;
    logic [CMP_W-1:0]  compare_value;

    // clock register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLOCK_RESET;
        end else if (cfg_wr_en) begin
            clock_hz_reg <= cfg_wr_data;
        end
    end

    // pipeline advances unless a result waits
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // clock over frequency
    tdp_div_pipe #(
        .NUM_W  (QUO_W),
        .DEN_W  (FREQ_W),
        .SIDE_W (FREQ_W)
    ) u_div_freq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid && s_tready),
        .in_num    (clock_hz_reg),
        .in_den    (s_tdata[FREQ_W-1:0]),
        .in_side   (s_tdata[FREQ_W-1:0]),
        .out_valid (q_valid),
        .out_quo   (q_quo),
        .out_side  (q_freq)
    );

    // rounded half period per prescaler: (q + p) / (2p)
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_prep
        logic [QUO_W:0] sum;
        logic [QUO_W:0] cnt;
        assign sum = {1'b0, q_quo} + (QUO_W+1)'(1 << PRESC_SHIFT[k]);
        assign cnt = sum >> (PRESC_SHIFT[k] + 1);

        always_ff @(posedge aclk) begin
            if (ce) begin
                prep_lane_reg[k].freq <= q_freq;
                if (cnt > (QUO_W+1)'(CNT_MAX)) begin
                    prep_lane_reg[k].skip <= 1'b1;
                    prep_lane_reg[k].cmp  <= '0;
                    prep_cnt_reg[k]       <= CNT_W'(1);
                end else if (cnt == '0) begin
                    prep_lane_reg[k].skip <= 1'b0;
                    prep_lane_reg[k].cmp  <= '0;
                    prep_cnt_reg[k]       <= CNT_W'(1);
                end else begin
                    prep_lane_reg[k].skip <= 1'b0;
                    prep_lane_reg[k].cmp  <= CMP_W'(cnt - 1'b1);
                    prep_cnt_reg[k]       <= cnt[CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (ce) begin
            prep_valid_reg <= q_valid;
        end
    end

    // produced frequency per prescaler: (clock / 2p) / count
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        logic [REAL_W-1:0] num;
        logic [$bits(tdp_lane_t)-1:0] side_out;
        assign num          = REAL_W'(clock_hz_reg >> (PRESC_SHIFT[k] + 1));
        assign lane_side[k] = tdp_lane_t'(side_out);

        tdp_div_pipe #(
            .NUM_W  (REAL_W),
            .DEN_W  (CNT_W),
            .SIDE_W ($bits(tdp_lane_t))
        ) u_div_real (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (prep_valid_reg),
            .in_num    (num),
            .in_den    (prep_cnt_reg[k]),
            .in_side   (prep_lane_reg[k]),
            .out_valid (lane_valid[k]),
            .out_quo   (lane_real[k]),
            .out_side  (side_out)
        );
    end

    tdp_pick u_pick (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ce              (ce),
        .in_valid        (lane_valid[0] && lane_valid[1] && lane_valid[2]),
        .lane            (lane_side),
        .real_freq       (lane_real),
        .out_valid       (pick_valid),
        .tone_on         (tone_on),
        .prescale_select (prescale_select),
        .compare_value   (compare_value)
    );

    assign m_tvalid = pick_valid;
    assign m_tdata  = {(M_DATA_W-1-SEL_W-CMP_W)'(0), compare_value, prescale_select, tone_on};

endmodule

[tb/tb.sv]
// testbench of the tone divider select block: directed and random tone requests checked
module tb;
    import tdp_pkg::*;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CLK_W-1:0]    cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;       // [15:0] tone_freq
    logic                m_tvalid;
    logic                m_tready;
    // [0] tone_on, [2:1] prescale_select, [18:3] compare_value, [23:19] zero
    logic [M_DATA_W-1:0] m_tdata;

    typedef struct packed {
        logic             tone_on;
        logic [SEL_W-1:0] sel;
        logic [CMP_W-1:0] cmp;
    } tone_setting_t;

    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned STALL_LIMIT  = 20000;

    tone_setting_t  pending_settings[$];
    logic [CLK_W-1:0] timer_clock;
    int unsigned    err_count;
    int unsigned    quiet_cycles;
    bit             idle_on;

    tone_divider_select uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // clock
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // best prescaler and compare value for one frequency
    function automatic tone_setting_t pick_divider(logic [CLK_W-1:0] clk_hz,
                                                    logic [FREQ_W-1:0] freq);
        tone_setting_t  best;
        longint unsigned min_err, den, n, cmp, real_f, err, p;
        best = '0;
        min_err = 64'hFFFF_FFFF_FFFF_FFFF;
        if (freq == 0) return best;
        best.tone_on = 1'b1;
        for (int i = 0; i < 3; i++) begin
            p = 64'd1 << (3 * i);
            den = 2 * p * freq;
            n = (clk_hz + den / 2) / den;
            if (n == 0) n = 1;
            cmp = n - 1;
            if (cmp > 65535) continue;
            real_f = clk_hz / (2 * p * (cmp + 1));
            err = (real_f > freq) ? real_f - freq : freq - real_f;
            if (err < min_err) begin
                min_err = err;
                best.cmp = cmp[CMP_W-1:0];
                best.sel = i[SEL_W-1:0];
            end
        end
        return best;
    endfunction

    // sender side: one transaction, valid stays high into a back to back transaction
    task automatic send_tone(logic [FREQ_W-1:0] freq);
        while (idle_on && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= freq;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_settings.push_back(pick_divider(timer_clock, freq));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_settings.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_clock(logic [CLK_W-1:0] clk_hz);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= clk_hz;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        timer_clock = clk_hz;
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= !(idle_on && $urandom_range(99) < 29);
    end

    // result checker
    always @(posedge aclk) begin
        tone_setting_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.tone_on = m_tdata[0];
            got.sel     = m_tdata[2:1];
            got.cmp     = m_tdata[18:3];
            if (pending_settings.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                err_count++;
            end else begin
                want = pending_settings.pop_front();
                if (got.tone_on !== want.tone_on) begin
                    $error("tone_on exp %0d got %0d", want.tone_on, got.tone_on);
                    err_count++;
                end
                if (got.sel !== want.sel) begin
                    $error("prescale_select exp %0d got %0d", want.sel, got.sel);
                    err_count++;
                end
                if (got.cmp !== want.cmp) begin
                    $error("compare_value exp %0d got %0d", want.cmp, got.cmp);
                    err_count++;
                end
            end
            if (m_tdata[23:19] !== '0) begin
                $error("padding exp 0 got %h", m_tdata[23:19]);
                err_count++;
            end
        end
    end

    // watchdog on transactions
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // field extremes and special cases at the reset clock
    task automatic test_directed();
        logic [FREQ_W-1:0] freqs[] = '{0, 1, 2, 3, 16'hFFFF, 16'h8000, 16'h5555,
                                      16'hAAAA, 440, 1000, 31, 122, 123, 245, 4000};
        foreach (freqs[i]) send_tone(freqs[i]);
    endtask

    // extremes of the clock, including out of range values
    task automatic test_clock_extremes();
        logic [CLK_W-1:0] clocks[] = '{1000000, 100000000, 0, 27'h7FFFFFF, 1};
        foreach (clocks[i]) begin
            set_clock(clocks[i]);
            send_tone(1);
            send_tone(7);
            send_tone(16'hFFFF);
            send_tone(1000);
        end
    endtask

    // random tones over random clocks
    task automatic test_random();
        for (int phase = 0; phase < 8; phase++) begin
            set_clock(phase == 0 ? 27'd16000000
                                 : CLK_W'($urandom_range(100000000, 1000000)));
            idle_on = (phase != 3);
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(3) == 0)
                    send_tone(FREQ_W'($urandom()));
                else
                    send_tone(FREQ_W'($urandom_range(5000, 1)));
                // sender waits for every pending result once
                if (k == 50 && phase == 5) wait_drained();
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        err_count   = 0;
        quiet_cycles = 0;
        idle_on     = 1'b1;
        timer_clock = CLOCK_RESET;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_clock_extremes();
        test_random();
        wait_drained();
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
